// ----- rtl/irmse_pkg.sv -----
// ----------------------------------------------------------------------------
// irmse_pkg
// Shared constants and controller/datapath interface types for the
// interval RMSE accumulator.
// ----------------------------------------------------------------------------
package irmse_pkg;

  // Sample format: two's complement with FRACTION_BITS fraction bits
  localparam int SAMPLE_BITS   = 32;
  localparam int FRACTION_BITS = 16;
  localparam int COUNT_BITS    = 32;

  // Port widths fixed by the interface
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 32;
  localparam int RMSE_W  = 32;

  // Accumulator and derived widths
  localparam int ACC_BITS   = 64;
  localparam int ROOT_BITS  = ACC_BITS / 2;
  localparam int DIV_STEPS  = ACC_BITS;
  localparam int SQRT_STEPS = ACC_BITS / 2;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;      // input channel may take a word
    logic div_init;    // load dividend and clear remainder
    logic div_step;    // one quotient bit
    logic sqrt_init;   // load radicand from quotient
    logic sqrt_step;   // one root bit
    logic load;        // move result to output register, clear accumulators
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic last_pending;  // a last word is still in the front pipeline
    logic last_acc;      // the last word accumulates this cycle
    logic count_zero;    // no existing pair counted
    logic out_busy;      // output register holds a word that stays this cycle
  } status_t;

endpackage

// ----- rtl/irmse_ctrl.sv -----
// ----------------------------------------------------------------------------
// irmse_ctrl
// Sequencer: accumulate phase, then mean division, square root and
// result hand-off (division and square root skipped with no pair counted).
// ----------------------------------------------------------------------------
module irmse_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  irmse_pkg::status_t status_i,
  output irmse_pkg::cmd_t    cmd_o
);
  import irmse_pkg::*;

  localparam logic [2:0] ST_ACC    = 3'd0;
  localparam logic [2:0] ST_START  = 3'd1;
  localparam logic [2:0] ST_DIV    = 3'd2;
  localparam logic [2:0] ST_SQINIT = 3'd3;
  localparam logic [2:0] ST_SQRT   = 3'd4;
  localparam logic [2:0] ST_LOAD   = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_ACC: begin
        cmd_o.accept = ~status_i.last_pending;
        if (status_i.last_acc) begin
          state_d = ST_START;
        end
      end
      ST_START: begin
        cnt_d = '0;
        if (status_i.count_zero) begin
          state_d = ST_LOAD;
        end else begin
          cmd_o.div_init = 1'b1;
          state_d        = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == STEP_W'(DIV_STEPS - 1)) begin
          state_d = ST_SQINIT;
        end
      end
      ST_SQINIT: begin
        cmd_o.sqrt_init = 1'b1;
        cnt_d           = '0;
        state_d         = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == STEP_W'(SQRT_STEPS - 1)) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (!status_i.out_busy) begin
          cmd_o.load = 1'b1;
          state_d    = ST_ACC;
        end
      end
      default: begin
        state_d = ST_ACC;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACC;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ----- rtl/irmse_dp.sv -----
// ----------------------------------------------------------------------------
// irmse_dp
// Datapath: difference, square and saturating accumulate pipeline,
// bit-serial divider, two-bit-per-step square root and output register.
// ----------------------------------------------------------------------------
module irmse_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  irmse_pkg::cmd_t                cmd_i,
  output irmse_pkg::status_t             status_o,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [irmse_pkg::VALUE_W-1:0]  expected_value_i,
  input  logic [irmse_pkg::VALUE_W-1:0]  lower_value_i,
  input  logic [irmse_pkg::VALUE_W-1:0]  upper_value_i,
  input  logic                           is_interval_i,
  input  logic                           exists_i,
  input  logic                           last_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [irmse_pkg::RMSE_W-1:0]   rmse_o,
  output logic [irmse_pkg::COUNT_W-1:0]  used_count_o,
  output logic                           empty_error_o,
  output logic                           sum_saturated_o
);
  import irmse_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic in_acc;
  assign in_ready_o = cmd_i.accept;
  assign in_acc     = in_valid_i & cmd_i.accept;

  // Stage A: difference magnitude
  logic signed [SAMPLE_BITS-1:0] exp_s, lo_s, hi_s, bound_s;
  logic signed [SAMPLE_BITS:0]   diff_s;
  logic        [SAMPLE_BITS:0]   mag_w;

  assign exp_s   = signed'(expected_value_i[SAMPLE_BITS-1:0]);
  assign lo_s    = signed'(lower_value_i[SAMPLE_BITS-1:0]);
  assign hi_s    = signed'(upper_value_i[SAMPLE_BITS-1:0]);
  assign bound_s = (is_interval_i && (hi_s < lo_s)) ? hi_s : lo_s;
  assign diff_s  = (SAMPLE_BITS+1)'(exp_s) - (SAMPLE_BITS+1)'(bound_s);
  assign mag_w   = diff_s[SAMPLE_BITS] ? unsigned'(-diff_s) : unsigned'(diff_s);

  logic                   a_vld_q, a_use_q, a_last_q;
  logic [SAMPLE_BITS-1:0] a_mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_use_q  <= exists_i;
      a_last_q <= last_i;
      a_mag_q  <= mag_w[SAMPLE_BITS-1:0];
    end
  end

  // Stage B: square
  logic                     b_vld_q, b_use_q, b_last_q;
  logic [2*SAMPLE_BITS-1:0] b_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_vld_q) begin
      b_use_q  <= a_use_q;
      b_last_q <= a_last_q;
      b_sq_q   <= a_mag_q * a_mag_q;
    end
  end

  // Saturating accumulate and pair count
  logic [ACC_BITS-1:0]   sum_q;
  logic [COUNT_BITS-1:0] count_q;
  logic                  sat_q;
  logic [ACC_BITS:0]     sum_ext;
  logic                  add_en;

  assign add_en  = b_vld_q & b_use_q;
  assign sum_ext = {1'b0, sum_q} + {1'b0, ACC_BITS'(b_sq_q)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
      sat_q   <= 1'b0;
    end else if (cmd_i.load) begin
      sum_q   <= '0;
      count_q <= '0;
      sat_q   <= 1'b0;
    end else if (add_en) begin
      if (sum_ext[ACC_BITS]) begin
        sum_q <= '1;
        sat_q <= 1'b1;
      end else begin
        sum_q <= sum_ext[ACC_BITS-1:0];
      end
      if (count_q != COUNT_MAX) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  // Restoring divider, one quotient bit per step
  logic [ACC_BITS-1:0]   quo_q;
  logic [COUNT_BITS-1:0] rem_q;
  logic [COUNT_BITS:0]   rem_sh, rem_sub;
  logic                  div_ge;

  assign rem_sh  = {rem_q, quo_q[ACC_BITS-1]};
  assign rem_sub = rem_sh - {1'b0, count_q};
  assign div_ge  = (rem_sh >= {1'b0, count_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      quo_q <= sum_q;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[ACC_BITS-2:0], div_ge};
      rem_q <= div_ge ? rem_sub[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
    end
  end

  // Digit-by-digit square root, two radicand bits per step
  logic [ACC_BITS-1:0]  rad_q;
  logic [ROOT_BITS-1:0] root_q;
  logic [ROOT_BITS+1:0] srem_q;
  logic [ROOT_BITS+3:0] srem_sh, trial, srem_sub;
  logic                 sq_ge;

  assign srem_sh  = {srem_q, rad_q[ACC_BITS-1 -: 2]};
  assign trial    = (ROOT_BITS+4)'({root_q, 2'b01});
  assign sq_ge    = (srem_sh >= trial);
  assign srem_sub = srem_sh - trial;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_init) begin
      rad_q  <= quo_q;
      root_q <= '0;
      srem_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      rad_q  <= {rad_q[ACC_BITS-3:0], 2'b00};
      root_q <= {root_q[ROOT_BITS-2:0], sq_ge};
      srem_q <= sq_ge ? srem_sub[ROOT_BITS+1:0] : srem_sh[ROOT_BITS+1:0];
    end
  end

  // Output register
  logic                  out_vld_q;
  logic [RMSE_W-1:0]     rmse_q;
  logic [COUNT_W-1:0]    ucount_q;
  logic                  empty_q, osat_q;
  logic                  count_zero;

  assign count_zero = (count_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rmse_q   <= count_zero ? '0 : RMSE_W'(root_q);
      ucount_q <= COUNT_W'(count_q);
      empty_q  <= count_zero;
      osat_q   <= sat_q & ~count_zero;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign rmse_o          = rmse_q;
  assign used_count_o    = ucount_q;
  assign empty_error_o   = empty_q;
  assign sum_saturated_o = osat_q;

  // Status back to the controller
  assign status_o.last_pending = (a_vld_q & a_last_q) | (b_vld_q & b_last_q);
  assign status_o.last_acc     = b_vld_q & b_last_q;
  assign status_o.count_zero   = count_zero;
  assign status_o.out_busy     = out_vld_q & ~out_ready_i;

endmodule

// ----- rtl/interval_rmse_accumulator_top.sv -----
// Sequence: a last word raises out_valid_o after pipeline stages A and B,
//   start, 64 divider steps, radicand load, 32 square root steps and
//   hand-off, held while out_busy; an empty vector skips divider and root.
// Throughput: one word per cycle while accumulating; after a last word no
//   word is taken until the result enters the output register.
// Reset: rst_ni asynchronous active low clears accumulator, count and flags.
// ----------------------------------------------------------------------------
// interval_rmse_accumulator_top
// Streaming RMSE over expected/produced pairs with interval support.
// ----------------------------------------------------------------------------
module interval_rmse_accumulator_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [irmse_pkg::VALUE_W-1:0]  expected_value_i,
  input  logic [irmse_pkg::VALUE_W-1:0]  lower_value_i,
  input  logic [irmse_pkg::VALUE_W-1:0]  upper_value_i,
  input  logic                           is_interval_i,
  input  logic                           exists_i,
  input  logic                           last_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [irmse_pkg::RMSE_W-1:0]   rmse_o,
  output logic [irmse_pkg::COUNT_W-1:0]  used_count_o,
  output logic                           empty_error_o,
  output logic                           sum_saturated_o
);
  import irmse_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer
  irmse_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // Arithmetic and storage
  irmse_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .expected_value_i (expected_value_i),
    .lower_value_i    (lower_value_i),
    .upper_value_i    (upper_value_i),
    .is_interval_i    (is_interval_i),
    .exists_i         (exists_i),
    .last_i           (last_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .rmse_o           (rmse_o),
    .used_count_o     (used_count_o),
    .empty_error_o    (empty_error_o),
    .sum_saturated_o  (sum_saturated_o)
  );

endmodule
